>>> src/pots_pkg.sv
`timescale 1ns / 1ps
// shared widths, codes, types and helper functions of the tube surface sampler
// no dependencies; imported by every module of the block
package pots_pkg;

   localparam int LEN_W = 32;
   localparam int FRAC_BITS = 16;
   localparam int RND_W = 32;
   localparam int CORDIC_STAGES = 24;
   localparam int OUT_W = 32;
   localparam int TURN_W = 32;

   localparam int RAD_W = 2 * LEN_W;
   localparam int ROOT_W = LEN_W;
   localparam int REM_W = ROOT_W + 3;
   localparam int TOTAL_W = 2 * LEN_W + 3;
   localparam int PICK_W = TOTAL_W + RND_W;
   localparam int CORD_W = 34;
   localparam int SAT_W = 40;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [1:0] ID_TOP = 2'd0;
   localparam logic [1:0] ID_BOTTOM = 2'd1;
   localparam logic [1:0] ID_OUTER = 2'd2;
   localparam logic [1:0] ID_INNER = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_INNER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [SAT_W-1:0] POS_LIM = SAT_W'(64'h7FFF_FFFF);
   localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(64'h8000_0000);

   typedef struct packed {
      logic [1:0] id;
      logic signed [OUT_W-1:0] z;
      logic [TURN_W-1:0] turn;
      logic [LEN_W-1:0] r_wall;
   } side_type;

   typedef struct packed {
      logic [1:0] id;
      logic signed [OUT_W-1:0] z;
      logic [LEN_W-1:0] r;
   } cord_side_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // magnitude plus sign to a saturated signed output
   function automatic logic signed [OUT_W-1:0] sat_out(input logic [SAT_W-1:0] mag,
                                                       input logic neg);
      logic signed [OUT_W-1:0] v;
      if (neg) begin
         if (mag >= NEG_LIM) v = OUT_W'(32'h8000_0000);
         else v = -$signed(mag[OUT_W-1:0]);
      end else begin
         if (mag > POS_LIM) v = OUT_W'(32'h7FFF_FFFF);
         else v = $signed(mag[OUT_W-1:0]);
      end
      return v;
   endfunction

endpackage

>>> src/pots_front.sv
`timescale 1ns / 1ps
// front end: surface areas, surface pick, cap radicand and z coordinate
// eight register stages; uses pots_pkg
module pots_front
   import pots_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [LEN_W-1:0]        inner,
   input  logic [LEN_W-1:0]        outer,
   input  logic [LEN_W-1:0]        height,
   input  logic [RND_W-1:0]        rand_face,
   input  logic [RND_W-1:0]        rand_first,
   input  logic [RND_W-1:0]        rand_second,
   output logic                    out_valid,
   output logic [RAD_W-1:0]        out_radicand,
   output side_type                out_side
);

   localparam logic [RND_W-1:0] HALF = RND_W'(1) << (RND_W - 1);

   typedef struct packed {
      logic [RAD_W-1:0] cap;
      logic [RAD_W+1:0] b3;
      logic [RAD_W-1:0] sq;
      logic [LEN_W-1:0] ri;
      logic [LEN_W-1:0] ro;
      logic [RND_W-1:0] ua;
      logic [RND_W-1:0] ub;
      logic signed [OUT_W-1:0] zwall;
      logic signed [OUT_W-1:0] ztop;
   } carry_type;

   logic [7:0] v_ff, v_in;

   logic [LEN_W-1:0] ri_1_ff, ro_1_ff, h_1_ff;
   logic [RND_W-1:0] uf_1_ff, ua_1_ff, ub_1_ff;

   logic [RAD_W-1:0] ri2_2_ff, ro2_2_ff, roh_2_ff, rih_2_ff;
   logic [RND_W-1:0] zd_2_ff, uf_2_ff, ua_2_ff, ub_2_ff;
   logic             zpos_2_ff;
   logic [LEN_W-1:0] h_2_ff, ri_2_ff, ro_2_ff;

   logic [RAD_W-1:0] cap_3_ff, ri2_3_ff, zp_3_ff;
   logic [RAD_W:0]   wo_3_ff, wi_3_ff;
   logic             zpos_3_ff;
   logic [LEN_W-1:0] h_3_ff, ri_3_ff, ro_3_ff;
   logic [RND_W-1:0] uf_3_ff, ua_3_ff, ub_3_ff;

   logic [RAD_W+1:0] b3_4_ff;
   logic [RAD_W-1:0] cap_4_ff, ri2_4_ff, cul_4_ff, cuh_4_ff;
   logic [RAD_W:0]   wi_4_ff;
   logic signed [OUT_W-1:0] zwall_4_ff, ztop_4_ff;
   logic [LEN_W-1:0] ri_4_ff, ro_4_ff;
   logic [RND_W-1:0] uf_4_ff, ua_4_ff, ub_4_ff;

   logic [TOTAL_W-1:0] total_5_ff;
   logic [RND_W-1:0]   uf_5_ff;
   carry_type          c5_in, c5_ff, c6_ff, c7_ff;

   logic [RAD_W-1:0]   pl_6_ff;
   logic [TOTAL_W-1:0] ph_6_ff;
   logic [PICK_W-1:0]  pick_7_ff;

   logic [RAD_W:0]   zsum_3;
   logic [1:0]       id_8;
   side_type         side_8;
   logic [RAD_W-1:0] radicand_ff;
   side_type         side_ff;

   assign v_in = {v_ff[6:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // rounding toward minus infinity for negative wall heights
   assign zsum_3 = {1'b0, zp_3_ff} + (RAD_W + 1)'({RND_W{1'b1}});

   always_comb begin
      c5_in.cap = cap_4_ff;
      c5_in.b3 = b3_4_ff;
      c5_in.sq = RAD_W'({2'b00, ri2_4_ff} + {2'b00, cuh_4_ff}
                        + (RAD_W + 2)'(cul_4_ff[RAD_W-1:RND_W]));
      c5_in.ri = ri_4_ff;
      c5_in.ro = ro_4_ff;
      c5_in.ua = ua_4_ff;
      c5_in.ub = ub_4_ff;
      c5_in.zwall = zwall_4_ff;
      c5_in.ztop = ztop_4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ri_1_ff <= (inner < outer) ? inner : outer;
         ro_1_ff <= outer;
         h_1_ff <= height;
         uf_1_ff <= rand_face;
         ua_1_ff <= rand_first;
         ub_1_ff <= rand_second;

         ri2_2_ff <= ri_1_ff * ri_1_ff;
         ro2_2_ff <= ro_1_ff * ro_1_ff;
         roh_2_ff <= ro_1_ff * h_1_ff;
         rih_2_ff <= ri_1_ff * h_1_ff;
         zpos_2_ff <= (ub_1_ff >= HALF);
         zd_2_ff <= (ub_1_ff >= HALF) ? (ub_1_ff - HALF) : (HALF - ub_1_ff);
         h_2_ff <= h_1_ff;
         ri_2_ff <= ri_1_ff;
         ro_2_ff <= ro_1_ff;
         uf_2_ff <= uf_1_ff;
         ua_2_ff <= ua_1_ff;
         ub_2_ff <= ub_1_ff;

         cap_3_ff <= ro2_2_ff - ri2_2_ff;
         wo_3_ff <= {roh_2_ff, 1'b0};
         wi_3_ff <= {rih_2_ff, 1'b0};
         zp_3_ff <= h_2_ff * zd_2_ff;
         zpos_3_ff <= zpos_2_ff;
         ri2_3_ff <= ri2_2_ff;
         h_3_ff <= h_2_ff;
         ri_3_ff <= ri_2_ff;
         ro_3_ff <= ro_2_ff;
         uf_3_ff <= uf_2_ff;
         ua_3_ff <= ua_2_ff;
         ub_3_ff <= ub_2_ff;

         b3_4_ff <= {1'b0, cap_3_ff, 1'b0} + {1'b0, wo_3_ff};
         cap_4_ff <= cap_3_ff;
         wi_4_ff <= wi_3_ff;
         cul_4_ff <= cap_3_ff[RND_W-1:0] * ua_3_ff;
         cuh_4_ff <= cap_3_ff[RAD_W-1:RND_W] * ua_3_ff;
         if (zpos_3_ff) begin
            zwall_4_ff <= sat_out(SAT_W'(zp_3_ff[RAD_W-1:RND_W]), 1'b0);
         end else begin
            zwall_4_ff <= sat_out(SAT_W'(zsum_3[RAD_W:RND_W]), 1'b1);
         end
         ztop_4_ff <= $signed({1'b0, h_3_ff[LEN_W-1:1]});
         ri2_4_ff <= ri2_3_ff;
         ri_4_ff <= ri_3_ff;
         ro_4_ff <= ro_3_ff;
         uf_4_ff <= uf_3_ff;
         ua_4_ff <= ua_3_ff;
         ub_4_ff <= ub_3_ff;

         total_5_ff <= {1'b0, b3_4_ff} + {2'b00, wi_4_ff};
         uf_5_ff <= uf_4_ff;
         c5_ff <= c5_in;

         pl_6_ff <= total_5_ff[RND_W-1:0] * uf_5_ff;
         ph_6_ff <= total_5_ff[TOTAL_W-1:RND_W] * uf_5_ff;
         c6_ff <= c5_ff;

         pick_7_ff <= PICK_W'({ph_6_ff, {RND_W{1'b0}}}) + PICK_W'(pl_6_ff);
         c7_ff <= c6_ff;

         radicand_ff <= c7_ff.sq;
         side_ff <= side_8;
      end
   end

   always_comb begin
      if (pick_7_ff < PICK_W'({c7_ff.cap, {RND_W{1'b0}}})) id_8 = ID_TOP;
      else if (pick_7_ff < PICK_W'({c7_ff.cap, 1'b0, {RND_W{1'b0}}})) id_8 = ID_BOTTOM;
      else if (pick_7_ff < PICK_W'({c7_ff.b3, {RND_W{1'b0}}})) id_8 = ID_OUTER;
      else id_8 = ID_INNER;

      side_8.id = id_8;
      case (id_8)
         ID_TOP: begin
            side_8.z = c7_ff.ztop;
            side_8.turn = c7_ff.ub;
         end
         ID_BOTTOM: begin
            side_8.z = -c7_ff.ztop;
            side_8.turn = c7_ff.ub;
         end
         default: begin
            side_8.z = c7_ff.zwall;
            side_8.turn = c7_ff.ua;
         end
      endcase
      side_8.r_wall = (id_8 == ID_OUTER) ? c7_ff.ro : c7_ff.ri;
   end

   assign out_valid = v_ff[7];
   assign out_radicand = radicand_ff;
   assign out_side = side_ff;

endmodule

>>> src/pots_sqrt.sv
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per register stage
// uses pots_pkg; side data travels alongside unchanged
module pots_sqrt
   import pots_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_radicand,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   logic [ROOT_W-1:0] v_ff;
   logic [REM_W-1:0]  rem_ff [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff [ROOT_W];
   side_type          side_ff [ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ROOT_W-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_prev, rem_t, trial;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      side_type          side_prev;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign root_prev = '0;
         assign rad_prev = in_radicand;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign rem_t = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1:RAD_W-2]};
      assign trial = REM_W'({root_prev, 2'b01});

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_t >= trial) begin
               rem_ff[k] <= rem_t - trial;
               root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= rem_t;
               root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
            rad_ff[k] <= {rad_prev[RAD_W-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

>>> src/pots_cordic.sv
`timescale 1ns / 1ps
// pipelined rotation-mode cordic: cosine and sine in Q4.30 of a turn fraction
// one micro-rotation per stage plus a quadrant stage; uses pots_pkg
module pots_cordic
   import pots_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [TURN_W-1:0]        in_turn,
   input  cord_side_type            in_side,
   output logic                     out_valid,
   output logic signed [CORD_W-1:0] out_cos,
   output logic signed [CORD_W-1:0] out_sin,
   output cord_side_type            out_side
);

   logic [CORDIC_STAGES:0]   v_ff;
   logic signed [CORD_W-1:0] x_ff [CORDIC_STAGES];
   logic signed [CORD_W-1:0] y_ff [CORDIC_STAGES];
   logic signed [CORD_W-1:0] z_ff [CORDIC_STAGES];
   logic [1:0]               quad_ff [CORDIC_STAGES];
   cord_side_type            side_ff [CORDIC_STAGES];
   logic signed [CORD_W-1:0] cos_ff, sin_ff;
   cord_side_type            oside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[CORDIC_STAGES-1:0], in_valid};
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [CORD_W-1:0] x_prev, y_prev, z_prev, step;
      logic [1:0]               quad_prev;
      cord_side_type            side_prev;

      if (i == 0) begin : g_first
         assign x_prev = CORDIC_GAIN;
         assign y_prev = '0;
         assign z_prev = $signed(CORD_W'(in_turn[TURN_W-3:0]));
         assign quad_prev = in_turn[TURN_W-1:TURN_W-2];
         assign side_prev = in_side;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
         assign quad_prev = quad_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign step = $signed(CORD_W'(atan_turn(5'(i))));

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_prev[CORD_W-1]) begin
               x_ff[i] <= x_prev - (y_prev >>> i);
               y_ff[i] <= y_prev + (x_prev >>> i);
               z_ff[i] <= z_prev - step;
            end else begin
               x_ff[i] <= x_prev + (y_prev >>> i);
               y_ff[i] <= y_prev - (x_prev >>> i);
               z_ff[i] <= z_prev + step;
            end
            quad_ff[i] <= quad_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         case (quad_ff[CORDIC_STAGES-1])
            2'd0: begin
               cos_ff <= x_ff[CORDIC_STAGES-1];
               sin_ff <= y_ff[CORDIC_STAGES-1];
            end
            2'd1: begin
               cos_ff <= -y_ff[CORDIC_STAGES-1];
               sin_ff <= x_ff[CORDIC_STAGES-1];
            end
            2'd2: begin
               cos_ff <= -x_ff[CORDIC_STAGES-1];
               sin_ff <= -y_ff[CORDIC_STAGES-1];
            end
            default: begin
               cos_ff <= y_ff[CORDIC_STAGES-1];
               sin_ff <= -x_ff[CORDIC_STAGES-1];
            end
         endcase
         oside_ff <= side_ff[CORDIC_STAGES-1];
      end
   end

   assign out_valid = v_ff[CORDIC_STAGES];
   assign out_cos = cos_ff;
   assign out_sin = sin_ff;
   assign out_side = oside_ff;

endmodule

>>> src/point_on_tube_surface_top.sv
`timescale 1ns / 1ps
// Point on tube surface sampler, top level.
// Maps three uniform random fractions per request to a point spread uniformly
// over the surface of a hollow tube (caps, outer wall, inner wall).
// Channels: req_* carries the three fractions, rsp_* the point and surface id,
// both valid/ready. csr_* writes inner radius, outer radius, height by index;
// always ready. Users must write it only with no request in flight; unenforced.
// Pipeline: 8 front stages, 32 square-root stages, 25 cordic stages, 3 scaling
// stages. Throughput: one request per cycle while no stall holds the flow; the
// figure is set by the pipeline, which holds one request per stage.
// Reset: clears all valid bits; inner radius 0, outer radius and height 1.0.
// Stall: while a result waits with rsp_ready low the whole pipeline holds and
// req_ready drops; nothing is lost or repeated.
// Depends on pots_pkg, pots_front, pots_sqrt and pots_cordic.
module point_on_tube_surface_top
   import pots_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [RND_W-1:0]        req_rand_face,
   input  logic [RND_W-1:0]        req_rand_first,
   input  logic [RND_W-1:0]        req_rand_second,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_pos_x,
   output logic signed [OUT_W-1:0] rsp_pos_y,
   output logic signed [OUT_W-1:0] rsp_pos_z,
   output logic [1:0]              rsp_surface_id,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [LEN_W-1:0]        csr_data
);

   localparam int PROD_W = LEN_W + CORD_W;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 29;

   logic [LEN_W-1:0] inner_ff, outer_ff, height_ff;
   logic             en;

   logic             fr_valid;
   logic [RAD_W-1:0] fr_radicand;
   side_type         fr_side;

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;
   cord_side_type     cd_side_in;

   logic                     cd_valid;
   logic signed [CORD_W-1:0] cd_cos, cd_sin;
   cord_side_type            cd_side;

   logic [2:0]               sv_ff;
   logic [CORD_W-1:0]        magx_1_ff, magy_1_ff;
   logic                     negx_1_ff, negy_1_ff, negx_2_ff, negy_2_ff;
   cord_side_type            side_1_ff, side_2_ff;
   logic [PROD_W-1:0]        px_2_ff, py_2_ff, px_r, py_r;
   logic signed [OUT_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic [1:0]               id_ff;

   assign en = !sv_ff[2] || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= '0;
         outer_ff <= LEN_W'(1) << FRAC_BITS;
         height_ff <= LEN_W'(1) << FRAC_BITS;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INNER: inner_ff <= csr_data;
            CSR_OUTER: outer_ff <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   pots_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid && req_ready),
      .inner        (inner_ff),
      .outer        (outer_ff),
      .height       (height_ff),
      .rand_face    (req_rand_face),
      .rand_first   (req_rand_first),
      .rand_second  (req_rand_second),
      .out_valid    (fr_valid),
      .out_radicand (fr_radicand),
      .out_side     (fr_side)
   );

   pots_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (fr_valid),
      .in_radicand (fr_radicand),
      .in_side     (fr_side),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // caps use the square root, walls their own radius
   always_comb begin
      cd_side_in.id = sq_side.id;
      cd_side_in.z = sq_side.z;
      cd_side_in.r = (sq_side.id == ID_TOP || sq_side.id == ID_BOTTOM) ?
                     sq_root : sq_side.r_wall;
   end

   pots_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_turn   (sq_side.turn),
      .in_side   (cd_side_in),
      .out_valid (cd_valid),
      .out_cos   (cd_cos),
      .out_sin   (cd_sin),
      .out_side  (cd_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else if (en) begin
         sv_ff <= {sv_ff[1:0], cd_valid};
      end
   end

   assign px_r = px_2_ff + ROUND_HALF;
   assign py_r = py_2_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         negx_1_ff <= cd_cos[CORD_W-1];
         negy_1_ff <= cd_sin[CORD_W-1];
         magx_1_ff <= cd_cos[CORD_W-1] ? CORD_W'(-cd_cos) : CORD_W'(cd_cos);
         magy_1_ff <= cd_sin[CORD_W-1] ? CORD_W'(-cd_sin) : CORD_W'(cd_sin);
         side_1_ff <= cd_side;

         px_2_ff <= side_1_ff.r * magx_1_ff;
         py_2_ff <= side_1_ff.r * magy_1_ff;
         negx_2_ff <= negx_1_ff;
         negy_2_ff <= negy_1_ff;
         side_2_ff <= side_1_ff;

         pos_x_ff <= sat_out(SAT_W'(px_r[PROD_W-1:30]), negx_2_ff);
         pos_y_ff <= sat_out(SAT_W'(py_r[PROD_W-1:30]), negy_2_ff);
         pos_z_ff <= side_2_ff.z;
         id_ff <= side_2_ff.id;
      end
   end

   assign rsp_valid = sv_ff[2];
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_pos_z = pos_z_ff;
   assign rsp_surface_id = id_ff;

`ifndef ASSERT_OFF
   a_top_z_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_surface_id == ID_TOP) |-> !rsp_pos_z[OUT_W-1])
      else $error("top cap point below the midplane");

   a_bottom_z_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_surface_id == ID_BOTTOM) |->
      (rsp_pos_z[OUT_W-1] || rsp_pos_z == 0))
      else $error("bottom cap point above the midplane");

   a_csr_outer: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == CSR_OUTER) |=>
      (outer_ff == $past(csr_data)))
      else $error("outer radius write lost");
`endif

endmodule
